// ===== design/lome_pkg.sv =====
// Package: shared types and constants for the limit order matching engine.
package lome_pkg;

  localparam int unsigned TraderW = 32;
  localparam int unsigned QtyW    = 32;
  localparam int unsigned PriceW  = 24;
  localparam int unsigned ValueW  = 57;

  localparam logic CurUah = 1'b0;
  localparam logic CurUsd = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJECT,
    ST_CHECK,
    ST_MUL,
    ST_EMIT,
    ST_POP
  } state_e;

  typedef struct packed {
    logic       load;
    logic       insert;
    logic       calc;
    logic       mul;
    logic       pop;
    logic       emit;
    logic       reject;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic is_buy;
    logic side_full;
    logic crossed;
    logic out_busy;
  } sts_t;

endpackage

// ===== design/lome_ctrl.sv =====
// Controller: sequences insertion, match checks, trades and result emission.
module lome_ctrl
  import lome_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    cmd_o         = '0;
    cmd_o.phase   = phase_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REJECT;
        end
      end
      ST_REJECT: begin
        if (sts_i.side_full) begin
          if (!sts_i.out_busy) begin
            cmd_o.reject = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.crossed) begin
          cmd_o.calc = 1'b1;
          state_d    = ST_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        phase_d   = '0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          phase_d    = phase_q + 2'd1;
          if (phase_q == 2'd3) state_d = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_CHECK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/lome_dp.sv =====
// Datapath: both sorted books, trade arithmetic and the output register.
module lome_dp
  import lome_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TraderW-1:0]  trader_i,
  input  logic [QtyW-1:0]     qty_i,
  input  logic [PriceW-1:0]   price_i,
  input  logic                buy_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [TraderW-1:0]  acct_o,
  output logic [ValueW-1:0]   value_o,
  output logic                usd_o,
  output logic                status_o,
  output logic                last_o
);

  localparam int unsigned CntW = $clog2(BOOK_DEPTH + 1);

  logic [TraderW-1:0] bt_q [BOOK_DEPTH];
  logic [QtyW-1:0]    bq_q [BOOK_DEPTH];
  logic [PriceW-1:0]  bp_q [BOOK_DEPTH];
  logic [TraderW-1:0] at_q [BOOK_DEPTH];
  logic [QtyW-1:0]    aq_q [BOOK_DEPTH];
  logic [PriceW-1:0]  ap_q [BOOK_DEPTH];
  logic [CntW-1:0]    bcnt_q, acnt_q;

  logic [TraderW-1:0] it_q;
  logic [QtyW-1:0]    iq_q;
  logic [PriceW-1:0]  ip_q;
  logic               ib_q;

  logic [QtyW-1:0]    tq_q;
  logic [ValueW-1:0]  cost_q;
  logic [PriceW-1:0]  tp_q;
  logic [TraderW-1:0] seller_q, buyer_q;
  logic               traded_q;

  logic               ov_q;
  logic [TraderW-1:0] oa_q;
  logic [ValueW-1:0]  oval_q;
  logic               ousd_q, ost_q, olast_q;

  logic [BOOK_DEPTH-1:0] bgo, ago;
  logic [QtyW-1:0]       tq_d;
  logic                  a_rem, b_rem, crossed;
  logic                  a_nxt, b_nxt, x_nxt;

  assign crossed = (bcnt_q != '0) && (acnt_q != '0) && (ap_q[0] <= bp_q[0]);
  assign tq_d    = (aq_q[0] < bq_q[0]) ? aq_q[0] : bq_q[0];
  assign a_rem   = (aq_q[0] == '0);
  assign b_rem   = (bq_q[0] == '0);

  // Crossing after the pop is known at emit of the final word: the pop only
  // removes zero-quantity fronts, so precompute from post-trade fronts.
  assign a_nxt = (acnt_q - CntW'(a_rem)) != '0;
  assign b_nxt = (bcnt_q - CntW'(b_rem)) != '0;
  assign x_nxt = a_nxt && b_nxt &&
                 ((a_rem ? ap_q[1 % BOOK_DEPTH] : ap_q[0]) <=
                  (b_rem ? bp_q[1 % BOOK_DEPTH] : bp_q[0]));

  // Entry i moves down only when the new order sorts strictly before it.
  always_comb begin
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      bgo[i] = (CntW'(i) < bcnt_q) && !(bp_q[i] >= ip_q);
      ago[i] = (CntW'(i) < acnt_q) && !(ap_q[i] <= ip_q);
    end
  end

  assign sts_o.is_buy    = ib_q;
  assign sts_o.side_full = ib_q ? (bcnt_q >= CntW'(BOOK_DEPTH))
                                : (acnt_q >= CntW'(BOOK_DEPTH));
  assign sts_o.crossed   = crossed;
  assign sts_o.out_busy  = ov_q && !m_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q <= trader_i;
      iq_q <= qty_i;
      ip_q <= price_i;
      ib_q <= buy_i;
    end
    if (cmd_i.calc) begin
      tq_q     <= tq_d;
      tp_q     <= ap_q[0];
      seller_q <= at_q[0];
      buyer_q  <= bt_q[0];
    end
    if (cmd_i.mul) cost_q <= ValueW'(tq_q) * ValueW'(tp_q);
    if (cmd_i.insert && ib_q) begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        if (bgo[i]) begin
          if (i + 1 < BOOK_DEPTH) begin
            bt_q[(i+1)%BOOK_DEPTH] <= bt_q[i];
            bq_q[(i+1)%BOOK_DEPTH] <= bq_q[i];
            bp_q[(i+1)%BOOK_DEPTH] <= bp_q[i];
          end
        end
        if ((i == 0 || !bgo[(i+BOOK_DEPTH-1)%BOOK_DEPTH]) &&
            (bgo[i] || CntW'(i) == bcnt_q) &&
            (i == 0 || (CntW'(i) <= bcnt_q))) begin
          if (i == 0 ? 1'b1 : ((CntW'(i) <= bcnt_q) &&
              !bgo[(i+BOOK_DEPTH-1)%BOOK_DEPTH])) begin
            bt_q[i] <= it_q;
            bq_q[i] <= iq_q;
            bp_q[i] <= ip_q;
          end
        end
      end
    end
    if (cmd_i.insert && !ib_q) begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        if (ago[i]) begin
          if (i + 1 < BOOK_DEPTH) begin
            at_q[(i+1)%BOOK_DEPTH] <= at_q[i];
            aq_q[(i+1)%BOOK_DEPTH] <= aq_q[i];
            ap_q[(i+1)%BOOK_DEPTH] <= ap_q[i];
          end
        end
        if ((i == 0 || !ago[(i+BOOK_DEPTH-1)%BOOK_DEPTH]) &&
            (ago[i] || CntW'(i) == acnt_q) &&
            (i == 0 || (CntW'(i) <= acnt_q))) begin
          at_q[i] <= it_q;
          aq_q[i] <= iq_q;
          ap_q[i] <= ip_q;
        end
      end
    end
    if (cmd_i.calc) begin
      aq_q[0] <= aq_q[0] - tq_d;
      bq_q[0] <= bq_q[0] - tq_d;
    end
    if (cmd_i.pop) begin
      for (int i = 0; i + 1 < BOOK_DEPTH; i++) begin
        if (a_rem) begin
          at_q[i] <= at_q[i+1];
          aq_q[i] <= aq_q[i+1];
          ap_q[i] <= ap_q[i+1];
        end
        if (b_rem) begin
          bt_q[i] <= bt_q[i+1];
          bq_q[i] <= bq_q[i+1];
          bp_q[i] <= bp_q[i+1];
        end
      end
    end
    if (cmd_i.reject) begin
      oa_q    <= it_q;
      oval_q  <= '0;
      ousd_q  <= CurUah;
      ost_q   <= 1'b1;
      olast_q <= 1'b1;
    end else if (cmd_i.emit) begin
      ost_q <= 1'b0;
      case (cmd_i.phase)
        2'd0: begin
          oa_q    <= seller_q;
          oval_q  <= -ValueW'(tq_q);
          ousd_q  <= CurUah;
          olast_q <= 1'b0;
        end
        2'd1: begin
          oa_q    <= seller_q;
          oval_q  <= cost_q;
          ousd_q  <= CurUsd;
          olast_q <= 1'b0;
        end
        2'd2: begin
          oa_q    <= buyer_q;
          oval_q  <= ValueW'(tq_q);
          ousd_q  <= CurUah;
          olast_q <= 1'b0;
        end
        default: begin
          oa_q   <= buyer_q;
          oval_q <= -cost_q;
          ousd_q <= CurUsd;
          // last trade of this order when the fronts no longer cross after the pop
          olast_q <= !x_nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q   <= '0;
      acnt_q   <= '0;
      ov_q     <= 1'b0;
      traded_q <= 1'b0;
    end else begin
      if (cmd_i.insert) begin
        if (ib_q) bcnt_q <= bcnt_q + CntW'(1);
        else      acnt_q <= acnt_q + CntW'(1);
      end
      if (cmd_i.pop) begin
        if (a_rem) acnt_q <= acnt_q - CntW'(1);
        if (b_rem) bcnt_q <= bcnt_q - CntW'(1);
      end
      if (cmd_i.calc) traded_q <= 1'b1;
      if (cmd_i.load) traded_q <= 1'b0;
      if (cmd_i.emit || cmd_i.reject) ov_q <= 1'b1;
      else if (m_ready_i)             ov_q <= 1'b0;
    end
  end

  assign m_valid_o = ov_q;
  assign acct_o    = oa_q;
  assign value_o   = oval_q;
  assign usd_o     = ousd_q;
  assign status_o  = ost_q;
  assign last_o    = olast_q;

  a_cnt_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= CntW'(BOOK_DEPTH)) else $error("bid count overflow");
  a_cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acnt_q <= CntW'(BOOK_DEPTH)) else $error("ask count overflow");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> traded_q) else $error("emit without trade");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.reject) |-> !(ov_q && !m_ready_i))
    else $error("output overwrite");

endmodule

// ===== design/limit_order_matching_engine.sv =====
// Top level: limit order book with price-time priority matching.
// A rejection word is registered from the REJECT state once the output is free;
// the first trade word follows REJECT, CHECK, MUL and EMIT. A resting order
// passes REJECT and CHECK. Each trade passes check, multiply, four words and
// pop, paced by the single output register and the multiplier, plus stalls.
// Reset clears the book counts and output valid; book entries are not cleared.
module limit_order_matching_engine
  import lome_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // trader_id, quantity, limit_price
  input  logic         s_axis_tuser,  // is_buy
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // account_id, change_value, pad zeros
  output logic [1:0]   m_axis_tuser,  // currency_is_usd, status
  output logic         m_axis_tlast   // last_of_run
);

  cmd_t               cmd;
  sts_t               sts;
  logic [TraderW-1:0] acct;
  logic [ValueW-1:0]  val;
  logic               usd, st;

  lome_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
    .sts_i(sts), .cmd_o(cmd)
  );

  lome_dp #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .trader_i(s_axis_tdata[31:0]),
    .qty_i(s_axis_tdata[63:32]),
    .price_i(s_axis_tdata[87:64]),
    .buy_i(s_axis_tuser),
    .cmd_i(cmd), .sts_o(sts),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .acct_o(acct), .value_o(val), .usd_o(usd), .status_o(st),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, val, acct};
  assign m_axis_tuser = {st, usd};

endmodule
